### rtl/spws_pkg.sv
// Shared constants and types for the set permutation window search block.
package spws_pkg;

   localparam int BYTE_BITS      = 8;
   localparam int SYMBOLS        = 256;
   localparam int LEN_BITS       = 9;
   localparam int MASK_WORDS     = 4;
   localparam int MASK_BITS      = 64;
   localparam int WORD_IDX_BITS  = 2;
   localparam int WORD_CNT_BITS  = 7;
   localparam int RSP_COUNT_BITS = 32;
   localparam int POS_BITS_DEF   = 32;
   localparam int COUNT_BITS_DEF = 32;

   localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(SYMBOLS);

   // Membership lookup result handed from the mask registers to the datapath
   typedef struct packed {
      logic                member;
      logic [LEN_BITS-1:0] set_size;
   } set_info_type;

endpackage

### rtl/set_permutation_window_search.sv
// Top level of the set permutation window search block.
//
// Bytes enter on the req_ channel (req_byte_value, req_first_byte), one beat
// per cycle while req_stall is low. Each byte yields one rsp_ beat: rsp_match
// flags a window of distinct member bytes whose length equals the configured
// set size, rsp_window_length is that window length and rsp_match_count the
// low bits of the saturating match counter. The set is to be written through
// csr_ (index 0..3, one 64-bit mask word each) while no beat is in flight; the
// block does not enforce this. Throughput is one byte per cycle while no stall
// holds the flow. A byte's last-position lookup reads the table in the cycle
// of acceptance, and the update stage writes it back when it advances; a byte
// that follows the same value directly takes the position from a bypass.
// Reset clears masks, seen flags, position, window and count; the table needs
// no clearing since the seen flags guard every read. A stalled result holds in
// the output register while one more byte waits in the update stage; beyond
// that req_stall rises in the same cycle as rsp_stall.
module set_permutation_window_search
   import spws_pkg::*;
#(
   parameter int POS_BITS   = POS_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [WORD_IDX_BITS-1:0]  csr_index,
   input  logic [MASK_BITS-1:0]      csr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [BYTE_BITS-1:0]      req_byte_value,
   input  logic                      req_first_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_match,
   output logic [LEN_BITS-1:0]       rsp_window_length,
   output logic [RSP_COUNT_BITS-1:0] rsp_match_count
);

   // Handshake
   logic req_accept;
   logic s1_advance;

   // Update stage
   logic                  s1_valid_ff, s1_valid_in;
   logic [BYTE_BITS-1:0]  s1_byte_ff;
   logic                  s1_first_ff;
   logic                  fwd_hit_ff, fwd_hit_in;
   logic [POS_BITS-1:0]   fwd_pos_ff;

   // String state
   logic [SYMBOLS-1:0]    seen_ff, seen_in;
   logic [POS_BITS-1:0]   position_ff, position_in;
   logic [LEN_BITS-1:0]   window_ff, window_in;
   logic [COUNT_BITS-1:0] match_total_ff, match_total_in;

   // Output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_match_ff;
   logic [LEN_BITS-1:0]       rsp_len_ff;
   logic [RSP_COUNT_BITS-1:0] rsp_count_ff;

   // Datapath
   set_info_type          info;
   logic [POS_BITS-1:0]   ram_rd_data;
   logic [POS_BITS-1:0]   pos_eff;
   logic [LEN_BITS-1:0]   win_eff;
   logic [COUNT_BITS-1:0] cnt_eff;
   logic                  seen_eff;
   logic [POS_BITS-1:0]   last_pos;
   logic [POS_BITS-1:0]   pos_gap;
   logic                  in_window;
   logic                  hit;
   logic [63:0]           count_wide;

   assign req_accept = req_valid && !req_stall;
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;

   spws_mask_cfg u_mask_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .lookup_byte (s1_byte_ff),
      .info        (info)
   );

   spws_pos_ram #(
      .WIDTH (POS_BITS)
   ) u_pos_ram (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (req_byte_value),
      .rd_data (ram_rd_data),
      .wr_en   (s1_advance && info.member),
      .wr_addr (s1_byte_ff),
      .wr_data (pos_eff)
   );

   // Window update for the byte in the update stage
   always_comb begin
      pos_eff   = s1_first_ff ? '0 : position_ff;
      win_eff   = s1_first_ff ? '0 : window_ff;
      cnt_eff   = s1_first_ff ? '0 : match_total_ff;
      seen_eff  = !s1_first_ff && seen_ff[s1_byte_ff];
      last_pos  = fwd_hit_ff ? fwd_pos_ff : ram_rd_data;
      pos_gap   = pos_eff - last_pos;
      in_window = seen_eff && (pos_gap != '0) && (pos_gap <= POS_BITS'(win_eff));

      if (!info.member) begin
         window_in = '0;
      end else if (in_window) begin
         window_in = pos_gap[LEN_BITS-1:0];
      end else if (win_eff < LEN_MAX) begin
         window_in = win_eff + 1'b1;
      end else begin
         window_in = win_eff;
      end

      hit = info.member && (window_in == info.set_size);
      match_total_in = (hit && !(&cnt_eff)) ? cnt_eff + 1'b1 : cnt_eff;
      position_in    = pos_eff + 1'b1;

      seen_in = s1_first_ff ? '0 : seen_ff;
      if (info.member) begin
         seen_in[s1_byte_ff] = 1'b1;
      end

      // Bypass when the next byte reads the entry being written now
      fwd_hit_in  = s1_advance && info.member && (s1_byte_ff == req_byte_value);
      s1_valid_in = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_advance ? 1'b1 : ((rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff);
      count_wide   = 64'(match_total_in);
   end

   // Control and string state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         fwd_hit_ff     <= 1'b0;
         seen_ff        <= '0;
         position_ff    <= '0;
         window_ff      <= '0;
         match_total_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            fwd_hit_ff <= fwd_hit_in;
         end
         if (s1_advance) begin
            seen_ff        <= seen_in;
            position_ff    <= position_in;
            window_ff      <= window_in;
            match_total_ff <= match_total_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff  <= req_byte_value;
         s1_first_ff <= req_first_byte;
         fwd_pos_ff  <= pos_eff;
      end
      if (s1_advance) begin
         rsp_match_ff <= hit;
         rsp_len_ff   <= window_in;
         rsp_count_ff <= count_wide[RSP_COUNT_BITS-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match         = rsp_match_ff;
   assign rsp_window_length = rsp_len_ff;
   assign rsp_match_count   = rsp_count_ff;

   // A match always comes with a non-empty window
   a_match_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_match_ff |-> rsp_len_ff != '0)
      else $error("match reported with empty window");

   // Window length never exceeds the symbol count
   a_len_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_len_ff <= LEN_MAX)
      else $error("window length beyond limit");

   // Input is held back only while the update stage is occupied
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty update stage");

   // A saturated count stays saturated within a string
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      s1_advance && !s1_first_ff && (&match_total_ff) |=> (&match_total_ff))
      else $error("match count left saturation");

endmodule

### rtl/spws_pos_ram.sv
// Last-position table: one write port, one read port, registered read data.
module spws_pos_ram
   import spws_pkg::*;
#(
   parameter int WIDTH = POS_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [BYTE_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data,
   input  logic                 wr_en,
   input  logic [BYTE_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data
);

   logic [WIDTH-1:0] mem [SYMBOLS];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/spws_mask_cfg.sv
// Membership mask registers, per-word population counts and set size.
module spws_mask_cfg
   import spws_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [WORD_IDX_BITS-1:0] csr_index,
   input  logic [MASK_BITS-1:0]     csr_data,
   input  logic [BYTE_BITS-1:0]     lookup_byte,
   output set_info_type             info
);

   logic [MASK_BITS-1:0]     mask_ff       [MASK_WORDS];
   logic [WORD_CNT_BITS-1:0] word_count_ff [MASK_WORDS];
   logic [LEN_BITS-1:0]      set_size_ff;
   logic [LEN_BITS-1:0]      set_size_in;
   logic [WORD_CNT_BITS-1:0] write_count;

   // Population count as eight byte counts and a short sum
   function automatic logic [WORD_CNT_BITS-1:0] word_popcount(input logic [MASK_BITS-1:0] w);
      logic [3:0]               part;
      logic [WORD_CNT_BITS-1:0] total;
      total = '0;
      for (int k = 0; k < MASK_BITS / 8; k++) begin
         part = '0;
         for (int j = 0; j < 8; j++) begin
            part = part + 4'(w[k*8 + j]);
         end
         total = total + WORD_CNT_BITS'(part);
      end
      return total;
   endfunction

   assign write_count = word_popcount(csr_data);

   always_comb begin
      set_size_in = '0;
      for (int i = 0; i < MASK_WORDS; i++) begin
         set_size_in = set_size_in + LEN_BITS'(word_count_ff[i]);
      end
   end

   // Mask words and counts; set size is registered from the stored word counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MASK_WORDS; i++) begin
            mask_ff[i]       <= '0;
            word_count_ff[i] <= '0;
         end
         set_size_ff <= '0;
      end else begin
         if (csr_write) begin
            mask_ff[csr_index]       <= csr_data;
            word_count_ff[csr_index] <= write_count;
         end
         set_size_ff <= set_size_in;
      end
   end

   assign info.member   = mask_ff[lookup_byte[BYTE_BITS-1:BYTE_BITS-WORD_IDX_BITS]]
                                 [lookup_byte[BYTE_BITS-WORD_IDX_BITS-1:0]];
   assign info.set_size = set_size_ff;

endmodule
